// ----- design/bglc_pkg.sv -----
// bglc_pkg: shared types, fixed-point constants and tables for the
// barometric ground-level calibrator. No dependencies.
package bglc_pkg;

	localparam int SAMPLE_W = 17;
	localparam int ALT_W    = 24;
	localparam int ACC_W    = 28;
	localparam int MEAN_W   = 25;
	localparam int LOG_W    = 35;

	localparam logic [16:0] SAMPLE_MAX   = 17'd110000;
	localparam logic [16:0] REF_PA       = 17'd101325;
	localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
	localparam logic [29:0] HALF_Q30     = 30'h2000_0000;
	localparam logic [27:0] EXPO_Q30     = 28'd204327700;
	localparam logic [29:0] LN2_Q30      = 30'd744261118;
	localparam logic [22:0] ALT_SCALE_CM = 23'd4433000;
	localparam logic [3:0]  EXP_TERMS    = 4'd14;

	// log2 in Q30 by repeated squaring; only evaluated for constants
	function automatic logic [LOG_W-1:0] log2_q30_const(input logic [31:0] x);
		logic [63:0] m;
		logic [63:0] res;
		int          e;
		e = 0;
		for (int i = 1; i < 30; i++) begin
			if ((x >> i) != 32'd0) e = i;
		end
		m   = 64'(x) << (30 - e);
		res = 64'(e) << 30;
		for (int k = 1; k <= 30; k++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m   = m >> 1;
				res = res + (64'd1 << (30 - k));
			end
		end
		return res[LOG_W-1:0];
	endfunction

	localparam logic [LOG_W-1:0] LOG2_REF = log2_q30_const(32'(REF_PA));

	// floor(2^31 / n) for the series term divisors
	function automatic logic [31:0] recip_q31(input logic [3:0] n);
		logic [31:0] r;
		case (n)
			4'd1:    r = 32'd2147483648;
			4'd2:    r = 32'd1073741824;
			4'd3:    r = 32'd715827882;
			4'd4:    r = 32'd536870912;
			4'd5:    r = 32'd429496729;
			4'd6:    r = 32'd357913941;
			4'd7:    r = 32'd306783378;
			4'd8:    r = 32'd268435456;
			4'd9:    r = 32'd238609294;
			4'd10:   r = 32'd214748364;
			4'd11:   r = 32'd195225786;
			4'd12:   r = 32'd178956970;
			4'd13:   r = 32'd165191049;
			4'd14:   r = 32'd153391689;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic write;
		logic update;
	} ring_ctl_t;

	typedef enum logic [2:0] {
		TS_IDLE, TS_SUM, TS_DIVGO, TS_DIV, TS_ALTGO, TS_ALT, TS_PUT
	} top_state_t;

	typedef enum logic [3:0] {
		AS_IDLE, AS_SQ, AS_NRM, AS_DIF, AS_MUL, AS_RND, AS_T,
		AS_EM, AS_ER, AS_EC, AS_R, AS_MAG, AS_MM, AS_DONE
	} alt_state_t;

endpackage

// ----- design/bglc_ring.sv -----
// bglc_ring: sample ring memory with per-entry valid bits and the running
// window sum (registered read-modify-write). Depends on bglc_pkg.
module bglc_ring #(
	parameter int DEPTH = 48,
	parameter int AW    = 6,
	parameter int SUM_W = 23
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bglc_pkg::ring_ctl_t            ctl,
	input  logic [bglc_pkg::SAMPLE_W-1:0]  sample,
	output logic [SUM_W-1:0]               win_sum
);
	import bglc_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	logic [AW-1:0]       pos_q;
	logic [AW-1:0]       nxt;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] rd_s1;
	logic [SAMPLE_W-1:0] x_s1;
	logic                rd_vld_s1;
	logic [SAMPLE_W-1:0] old;
	logic [SUM_W:0]      sum_add;

	assign nxt     = (pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
	assign old     = rd_vld_s1 ? rd_s1 : '0;
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(x_s1) - (SUM_W + 1)'(old);
	assign win_sum = sum_q;

	// write the current slot, read the one that leaves the window
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			mem[pos_q] <= sample;
			rd_s1      <= mem[nxt];
			x_s1       <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
			pos_q     <= '0;
			sum_q     <= '0;
		end else begin
			if (ctl.write) begin
				vld_q[pos_q] <= 1'b1;
				rd_vld_s1    <= vld_q[nxt];
			end
			if (ctl.update) begin
				sum_q <= sum_add[SUM_W-1:0];
				pos_q <= nxt;
			end
		end
	end

endmodule

// ----- design/bglc_div.sv -----
// bglc_div: division by a constant divisor through a reciprocal multiply and one
// correction step, both registered. No package dependency.
module bglc_div #(
	parameter int NUM_W   = 31,
	parameter int DIVISOR = 47
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	// floor(2^NUM_W / DIVISOR): the estimate is exact or one low
	localparam logic [NUM_W:0]   RECIP = (NUM_W + 1)'((64'd1 << NUM_W) / 64'(DIVISOR));
	localparam logic [NUM_W-1:0] DIV_K = NUM_W'(DIVISOR);

	logic                   busy_s1;
	logic [NUM_W-1:0]       num_s1;
	logic [2*NUM_W-1:0]     prod_s1;
	logic                   done_q;
	logic [NUM_W-1:0]       quo_q;
	logic [NUM_W-1:0]       est;
	logic [NUM_W-1:0]       rem;

	assign est  = prod_s1[2*NUM_W-1:NUM_W];
	assign rem  = num_s1 - est * DIV_K;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			busy_s1 <= start;
			done_q  <= busy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_s1  <= num;
			prod_s1 <= (2*NUM_W)'(num) * (2*NUM_W)'(RECIP);
		end
		if (busy_s1) quo_q <= (rem >= DIV_K) ? est + 1'b1 : est;
	end

endmodule

// ----- design/bglc_alt.sv -----
// bglc_alt: pressure-altitude sequencer: bit-serial log2 by squaring,
// exponent scaling, 14-term exp2 series, final scale. Depends on bglc_pkg.
module bglc_alt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [bglc_pkg::SAMPLE_W-1:0]       pres,
	output logic                                done,
	output logic signed [bglc_pkg::ALT_W-1:0]   alt
);
	import bglc_pkg::*;

	alt_state_t state_q, state_d;

	logic [4:0]       msb;
	logic [30:0]      m_init;
	logic [30:0]      m_q;
	logic [31:0]      sq_q;
	logic [4:0]       e_q;
	logic [29:0]      frac_q;
	logic [4:0]       bit_q;
	logic [LOG_W-1:0] res_w;
	logic             le_w;
	logic             le_q;
	logic [LOG_W-1:0] dif_q;
	logic [62:0]      prod_q;
	logic [2:0]       n_q;
	logic [30:0]      arg_q;
	logic [29:0]      t_q;
	logic [30:0]      term_q;
	logic [30:0]      v_q;
	logic [30:0]      qp_q;
	logic [3:0]       k_q;
	logic [32:0]      sum_q;
	logic [32:0]      r_q;
	logic [30:0]      dm_q;
	logic             neg_q;
	logic [ALT_W-1:0] alt_q;

	logic [61:0]      sq_full;
	logic [63:0]      rnd;
	logic [33:0]      d_w;
	logic [29:0]      f_w;
	logic [2:0]       n_w;
	logic [61:0]      tp;
	logic [61:0]      vp;
	logic [62:0]      rp;
	logic [34:0]      chk;
	logic [34:0]      rem;
	logic [30:0]      qc;
	logic [33:0]      rr;
	logic [33:0]      rsh;
	logic [54:0]      mp;
	logic [ALT_W-1:0] mag_w;

	always_comb begin
		msb = '0;
		for (int i = 0; i < SAMPLE_W; i++) begin
			if (pres[i]) msb = 5'(i);
		end
	end

	assign m_init  = {14'd0, pres} << (5'd30 - msb);
	assign res_w   = {e_q, frac_q};
	assign le_w    = res_w <= LOG2_REF;
	assign sq_full = 62'(m_q) * 62'(m_q);
	assign rnd     = {1'b0, prod_q} + 64'(HALF_Q30);
	assign d_w     = rnd[63:30];
	assign f_w     = d_w[29:0];
	assign n_w     = d_w[32:30];
	assign tp      = 62'(arg_q) * 62'(LN2_Q30) + 62'(HALF_Q30);
	assign vp      = 62'(term_q) * 62'(t_q) + 62'(HALF_Q30);
	assign rp      = 63'(v_q) * 63'(recip_q31(k_q));
	// reciprocal estimate is exact or one low
	assign chk     = 35'(qp_q) * 35'(k_q);
	assign rem     = 35'(v_q) - chk;
	assign qc      = (rem >= 35'(k_q)) ? qp_q + 31'd1 : qp_q;
	assign rr      = {1'b0, sum_q} + (34'd1 << n_q);
	assign rsh     = rr >> (4'(n_q) + 4'd1);
	assign mp      = 55'(dm_q) * 55'(ALT_SCALE_CM) + 55'(HALF_Q30);
	assign mag_w   = mp[53:30];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			AS_IDLE: begin
				if (start) state_d = (pres == '0) ? AS_DONE : AS_SQ;
			end
			AS_SQ:   state_d = AS_NRM;
			AS_NRM:  state_d = (bit_q == 5'd0) ? AS_DIF : AS_SQ;
			AS_DIF:  state_d = AS_MUL;
			AS_MUL:  state_d = AS_RND;
			AS_RND:  state_d = (le_q && f_w == '0) ? AS_MAG : AS_T;
			AS_T:    state_d = AS_EM;
			AS_EM:   state_d = AS_ER;
			AS_ER:   state_d = AS_EC;
			AS_EC:   state_d = (k_q == EXP_TERMS) ? AS_R : AS_EM;
			AS_R:    state_d = AS_MAG;
			AS_MAG:  state_d = AS_MM;
			AS_MM:   state_d = AS_DONE;
			AS_DONE: state_d = AS_IDLE;
			default: state_d = AS_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == AS_DONE);
		alt  = alt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= AS_IDLE;
			bit_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == AS_IDLE && start) bit_q <= 5'd29;
			else if (state_q == AS_NRM)      bit_q <= bit_q - 5'd1;
			if (state_q == AS_T)             k_q <= 4'd1;
			else if (state_q == AS_EC)       k_q <= k_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			AS_IDLE: begin
				if (start) begin
					m_q    <= m_init;
					e_q    <= msb;
					frac_q <= '0;
					alt_q  <= {1'b0, ALT_SCALE_CM};
				end
			end
			AS_SQ: sq_q <= sq_full[61:30];
			AS_NRM: begin
				if (sq_q[31]) begin
					m_q           <= sq_q[31:1];
					frac_q[bit_q] <= 1'b1;
				end else begin
					m_q <= sq_q[30:0];
				end
			end
			AS_DIF: begin
				dif_q <= le_w ? LOG2_REF - res_w : res_w - LOG2_REF;
				le_q  <= le_w;
			end
			AS_MUL: prod_q <= 63'(dif_q) * 63'(EXPO_Q30);
			AS_RND: begin
				// below reference: 2^-d = 2^(1-f) >> (n+1)
				n_q   <= n_w;
				r_q   <= 33'(ONE_Q30) >> n_w;
				arg_q <= le_q ? ONE_Q30 - {1'b0, f_w} : d_w[30:0];
			end
			AS_T: begin
				t_q    <= tp[59:30];
				term_q <= ONE_Q30;
				sum_q  <= 33'(ONE_Q30);
			end
			AS_EM: v_q <= vp[60:30];
			AS_ER: qp_q <= rp[61:31];
			AS_EC: begin
				term_q <= qc;
				sum_q  <= sum_q + 33'(qc);
			end
			AS_R: r_q <= le_q ? rsh[32:0] : sum_q;
			AS_MAG: begin
				if (r_q <= 33'(ONE_Q30)) begin
					dm_q  <= 31'(33'(ONE_Q30) - r_q);
					neg_q <= 1'b0;
				end else begin
					dm_q  <= 31'(r_q - 33'(ONE_Q30));
					neg_q <= 1'b1;
				end
			end
			AS_MM: alt_q <= neg_q ? (~mag_w + 24'd1) : mag_w;
			default: ;
		endcase
	end

endmodule

// ----- design/baro_ground_level_calibrator.sv -----
// baro_ground_level_calibrator: top level; sequencer, low-pass accumulator
// and output register. Depends on bglc_pkg, bglc_ring, bglc_div, bglc_alt.
//
// Usage:
//   Input channel in_valid/in_ready carries one pressure sample (Pa, values
//   above 110000 are clamped). Output channel out_valid/out_ready carries one
//   result per sample: smoothed ground pressure and its altitude in cm.
//   One sample is in flight at a time. The ring slot is written and the
//   leaving entry read, then the window sum is updated; the window mean follows
//   (start, reciprocal multiply, correction), and the altitude comes from a
//   sequencer that runs log2 squaring and then the exp2 series. Once the result
//   is in the output register the next sample can be taken. Zero ground
//   pressure skips the log/exp work, and at or below the reference pressure an
//   exponent with no fraction bits skips the exp2 series.
//   The result sits in an output register, so a new sample is taken while it
//   waits; if the receiver still stalls when the next result is ready, the
//   sequencer holds in its final state until the register frees up.
//   Reset clears the ring through per-entry valid bits (no clearing sweep),
//   the window sum, the ring position and the accumulator.
module baro_ground_level_calibrator #(
	parameter int RING_DEPTH = 48
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bglc_pkg::SAMPLE_W-1:0]       pressure_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bglc_pkg::SAMPLE_W-1:0]       base_pressure,
	output logic signed [bglc_pkg::ALT_W-1:0]   ground_altitude_cm
);
	import bglc_pkg::*;

	localparam int AW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W  = $clog2((RING_DEPTH - 1) * 110000 + 1);
	localparam int DIVN_W = SUM_W + 8;

	top_state_t state_q, state_d;

	ring_ctl_t           ring_ctl;
	logic [SAMPLE_W-1:0] x_sat;
	logic [SUM_W-1:0]    win_sum;
	logic                div_start;
	logic                div_done;
	logic [DIVN_W-1:0]   div_quo;
	logic                alt_start;
	logic                alt_done;
	logic [ALT_W-1:0]    alt_val;
	logic                put;
	logic [ACC_W-1:0]    acc_q;
	logic [SAMPLE_W-1:0] acc_hi;
	logic [SAMPLE_W-1:0] gp_w;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] gp_out_q;
	logic [ALT_W-1:0]    alt_out_q;

	assign x_sat  = (pressure_sample > SAMPLE_MAX) ? SAMPLE_MAX : pressure_sample;
	assign acc_hi = acc_q[ACC_W-1:11];
	assign gp_w   = (acc_hi > SAMPLE_MAX) ? SAMPLE_MAX : acc_hi;

	bglc_ring #(
		.DEPTH (RING_DEPTH),
		.AW    (AW),
		.SUM_W (SUM_W)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.sample  (x_sat),
		.win_sum (win_sum)
	);

	bglc_div #(
		.NUM_W   (DIVN_W),
		.DIVISOR (RING_DEPTH - 1)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({win_sum, 8'd0}),
		.done   (div_done),
		.quo    (div_quo)
	);

	bglc_alt u_alt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alt_start),
		.pres   (gp_w),
		.done   (alt_done),
		.alt    (alt_val)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			TS_IDLE:  if (in_valid) state_d = TS_SUM;
			TS_SUM:   state_d = TS_DIVGO;
			TS_DIVGO: state_d = TS_DIV;
			TS_DIV:   if (div_done) state_d = TS_ALTGO;
			TS_ALTGO: state_d = TS_ALT;
			TS_ALT:   if (alt_done) state_d = TS_PUT;
			TS_PUT:   if (!out_valid_q || out_ready) state_d = TS_IDLE;
			default:  state_d = TS_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = (state_q == TS_IDLE);
		ring_ctl.write  = (state_q == TS_IDLE) && in_valid;
		ring_ctl.update = (state_q == TS_SUM);
		div_start       = (state_q == TS_DIVGO);
		alt_start       = (state_q == TS_ALTGO);
		put             = (state_q == TS_PUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == TS_DIV && div_done) begin
				acc_q <= acc_q - (acc_q >> 3) + ACC_W'(div_quo[MEAN_W-1:0]);
			end
			if (put)            out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (put) begin
			gp_out_q  <= gp_w;
			alt_out_q <= alt_val;
		end
	end

	assign out_valid          = out_valid_q;
	assign base_pressure      = gp_out_q;
	assign ground_altitude_cm = alt_out_q;

endmodule

// ----- design/bglc_checker.sv -----
// bglc_checker: port-level assertions for the calibrator, bound to the top.
// Depends on bglc_pkg and baro_ground_level_calibrator.
module bglc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [bglc_pkg::SAMPLE_W-1:0]       pressure_sample,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [bglc_pkg::SAMPLE_W-1:0]       base_pressure,
	input logic signed [bglc_pkg::ALT_W-1:0]   ground_altitude_cm
);
	import bglc_pkg::*;

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(base_pressure)
			&& $stable(ground_altitude_cm))
		else $error("result changed while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(pressure_sample))
		else $error("input dropped or changed while stalled");

	// one sample in flight: no transfer in the cycle after one
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken back to back");

	a_gp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> base_pressure <= SAMPLE_MAX)
		else $error("ground pressure above clamp");

	a_zero_alt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && base_pressure == '0 |->
			ground_altitude_cm == $signed({1'b0, ALT_SCALE_CM}))
		else $error("zero pressure altitude wrong");

endmodule

bind baro_ground_level_calibrator bglc_checker u_bglc_checker (.*);

// ----- bench/tb_baro_ground_level_calibrator.sv -----
// tb_baro_ground_level_calibrator: self-checking bench for the ground-level calibrator.
// It predicts ground pressure and altitude for each sample transfer and checks them
// in order against the results. Depends on bglc_pkg and baro_ground_level_calibrator.
module tb_baro_ground_level_calibrator;
	timeunit 1ns;
	timeprecision 1ps;

	import bglc_pkg::SAMPLE_W;
	import bglc_pkg::ALT_W;

	localparam int RING_DEPTH     = 48;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int DRAIN_CYCLES   = 300;
	localparam int SINK_HOLD_LONG = 900;

	localparam logic [16:0] SAMPLE_CLAMP = 17'd110000;
	localparam logic [16:0] SEA_LEVEL_PA = 17'd101325;
	localparam logic [63:0] FIX_ONE      = 64'd1 << 30;
	localparam logic [63:0] FIX_HALF     = 64'd1 << 29;
	localparam logic [63:0] BARO_EXPO    = 64'd204327700;
	localparam logic [63:0] LN2_FIX      = 64'd744261118;
	localparam logic [63:0] CM_SCALE     = 64'd4433000;
	localparam logic [63:0] WINDOW_DIV   = 64'(RING_DEPTH - 1);

	typedef struct packed {
		logic [SAMPLE_W-1:0]     pressure;
		logic signed [ALT_W-1:0] altitude;
	} ground_result_t;

	logic                          clk;
	logic                          arst_n          = 1'b0;
	logic                          in_valid        = 1'b0;
	logic                          in_ready;
	logic [SAMPLE_W-1:0]           pressure_sample = '0;
	logic                          out_valid;
	logic                          out_ready       = 1'b0;
	logic [SAMPLE_W-1:0]           base_pressure;
	logic signed [ALT_W-1:0]       ground_altitude_cm;

	// predictor state
	logic [16:0] ring_hist [RING_DEPTH];
	int unsigned ring_idx;
	logic [22:0] win_sum;
	logic [27:0] lp_acc;

	ground_result_t expected_ground[$];
	int  mismatch_count = 0;
	int  cycle_count    = 0;
	bit  idling_on      = 1'b1;
	int  sink_hold_req  = 0;

	baro_ground_level_calibrator #(
		.RING_DEPTH(RING_DEPTH)
	) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pressure_sample   (pressure_sample),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.base_pressure     (base_pressure),
		.ground_altitude_cm(ground_altitude_cm)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// log2 in Q30: integer part from the top bit, fraction by repeated squaring
	function automatic logic [63:0] log2_fix30(input logic [31:0] x);
		int          e;
		logic [63:0] m;
		logic [63:0] res;
		e = 0;
		while (e < 29 && (x >> (e + 1)) != 32'd0)
			e++;
		m   = 64'(x) << (30 - e);
		res = 64'(e) << 30;
		for (int k = 1; k <= 30; k++) begin
			m = (m * m) >> 30;
			if (m >= (FIX_ONE << 1)) begin
				m   = m >> 1;
				res = res + (64'd1 << (30 - k));
			end
		end
		return res;
	endfunction

	// 2^f, f in Q30 on [0,1], as a 14-term series of e^(f*ln2)
	function automatic logic [63:0] exp2_fix30(input logic [63:0] f);
		logic [63:0] t;
		logic [63:0] term;
		logic [63:0] total;
		if (f > FIX_ONE)
			f = FIX_ONE;
		t     = (f * LN2_FIX + FIX_HALF) >> 30;
		term  = FIX_ONE;
		total = FIX_ONE;
		for (int n = 1; n <= 14; n++) begin
			term  = ((term * t + FIX_HALF) >> 30) / 64'(n);
			total = total + term;
		end
		return total;
	endfunction

	function automatic logic signed [ALT_W-1:0] alt_from_pressure(input logic [16:0] p);
		logic [63:0] lp;
		logic [63:0] lr;
		logic [63:0] r;
		logic [63:0] d;
		logic [63:0] whole;
		logic [63:0] frac;
		logic [63:0] mag;
		if (p == 17'd0)
			return ALT_W'(CM_SCALE);
		lp = log2_fix30(32'(p));
		lr = log2_fix30(32'(SEA_LEVEL_PA));
		if (lp <= lr) begin
			// negative exponent: 2^(1-frac) shifted down by whole+1, rounded; 1 >> whole if no fraction
			d     = ((lr - lp) * BARO_EXPO + FIX_HALF) >> 30;
			whole = d >> 30;
			frac  = d & (FIX_ONE - 64'd1);
			if (whole > 64'd40)
				whole = 64'd40;
			if (frac == 64'd0)
				r = FIX_ONE >> whole;
			else
				r = (exp2_fix30(FIX_ONE - frac) + (64'd1 << whole)) >> (whole + 64'd1);
		end else begin
			r = exp2_fix30(((lp - lr) * BARO_EXPO + FIX_HALF) >> 30);
		end
		if (r <= FIX_ONE) begin
			mag = ((FIX_ONE - r) * CM_SCALE + FIX_HALF) >> 30;
			return ALT_W'(mag);
		end
		mag = ((r - FIX_ONE) * CM_SCALE + FIX_HALF) >> 30;
		return ALT_W'(-mag);
	endfunction

	// advance the ring, window sum and low-pass accumulator by one sample
	function automatic ground_result_t track_ground(input logic [16:0] raw);
		logic [16:0]    x;
		int unsigned    nxt;
		logic [63:0]    g;
		ground_result_t r;
		x = (raw > SAMPLE_CLAMP) ? SAMPLE_CLAMP : raw;
		ring_hist[ring_idx] = x;
		win_sum  = win_sum + x;
		nxt      = (ring_idx + 1) % RING_DEPTH;
		win_sum  = win_sum - ring_hist[nxt];
		ring_idx = nxt;
		lp_acc   = 28'(64'(lp_acc) - 64'(lp_acc >> 3) + (64'(win_sum) * 64'd256) / WINDOW_DIV);
		g          = 64'(lp_acc >> 11);
		r.pressure = (g > 64'(SAMPLE_CLAMP)) ? SAMPLE_CLAMP : 17'(g);
		r.altitude = alt_from_pressure(r.pressure);
		return r;
	endfunction

	// valid is left high; the caller lowers it when it stops sending
	task automatic offer_sample(input logic [16:0] s);
		in_valid        <= 1'b1;
		pressure_sample <= s;
		do
			@(posedge clk);
		while (!in_ready);
		expected_ground.push_back(track_ground(s));
	endtask

	task automatic sender_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic sender_maybe_idle();
		if (idling_on && $urandom_range(0, 4) == 0)
			sender_gap($urandom_range(1, 12));
	endtask

	task automatic test_directed_extremes();
		logic [16:0] pat [$];
		pat = '{17'd0, 17'd0, 17'd1, 17'd110000, 17'd110001, 17'h1FFFF, 17'h15555,
			17'h0AAAA, 17'h10000, 17'd101325, 17'd101326, 17'd101324, 17'd0,
			17'h1FFFF, 17'd110000, 17'd110000, 17'd2, 17'd65535, 17'd0, 17'd50000};
		foreach (pat[i]) begin
			offer_sample(pat[i]);
			sender_maybe_idle();
		end
	endtask

	// steady runs at a random level dominate, so the window and accumulator settle;
	// long runs at zero and above sea level reach the two ends of the altitude curve
	task automatic test_settled_ground(input int n_items);
		int sent;
		int kind;
		int run_len;
		int base;
		int jitter;
		int v;
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 19);
			if (kind < 3) begin
				run_len = $urandom_range(1, 6);
				if (run_len > n_items - sent)
					run_len = n_items - sent;
				repeat (run_len) begin
					offer_sample(17'($urandom_range(0, 131071)));
					sender_maybe_idle();
					sent++;
				end
			end else begin
				if (kind < 5) begin
					base    = 0;
					run_len = $urandom_range(60, 150);
				end else if (kind < 8) begin
					base    = $urandom_range(101325, 131071);
					run_len = $urandom_range(60, 120);
				end else begin
					base    = $urandom_range(0, 110000);
					run_len = $urandom_range(10, 60);
				end
				if (run_len > n_items - sent)
					run_len = n_items - sent;
				jitter = (base == 0) ? 0 : $urandom_range(0, 200);
				repeat (run_len) begin
					v = base + int'($urandom_range(0, 2 * jitter)) - jitter;
					if (v < 0)
						v = 0;
					if (v > 131071)
						v = 131071;
					offer_sample(17'(v));
					sender_maybe_idle();
					sent++;
				end
			end
		end
	endtask

	// receiver stalls long enough for the output register and sequencer to fill
	task automatic test_output_backpressure();
		sink_hold_req = SINK_HOLD_LONG;
		repeat (10)
			offer_sample(17'($urandom_range(90000, 110000)));
	endtask

	task automatic test_drain_pause();
		repeat (6)
			offer_sample(17'($urandom_range(0, 131071)));
		in_valid <= 1'b0;
		while (expected_ground.size() != 0)
			@(posedge clk);
		repeat (14) begin
			offer_sample(17'($urandom_range(95000, 105000)));
			sender_maybe_idle();
		end
	endtask

	task automatic test_full_rate();
		idling_on = 1'b0;
		repeat (60)
			offer_sample(17'($urandom_range(0, 131071)));
	endtask

	// receiver: random stall bursts while idling is on, plus the long hold when one is requested
	initial begin : sink_proc
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (sink_hold_req != 0) begin
				stall_left    = sink_hold_req;
				sink_hold_req = 0;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
				if (idling_on && $urandom_range(0, 9) == 0)
					stall_left = $urandom_range(1, 12);
			end
		end
	end

	initial begin : result_check
		ground_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_ground.size() == 0) begin
					$error("result transfer with nothing expected: base_pressure %0d, ground_altitude_cm %0d",
						base_pressure, ground_altitude_cm);
					mismatch_count++;
				end else begin
					want = expected_ground.pop_front();
					if (base_pressure !== want.pressure) begin
						$error("base_pressure mismatch: expected %0d, actual %0d",
							want.pressure, base_pressure);
						mismatch_count++;
					end
					if (ground_altitude_cm !== want.altitude) begin
						$error("ground_altitude_cm mismatch: expected %0d, actual %0d",
							want.altitude, ground_altitude_cm);
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("tb_baro_ground_level_calibrator NOT OK");
				$finish;
			end
		end
	end

	initial begin : main_seq
		for (int i = 0; i < RING_DEPTH; i++)
			ring_hist[i] = '0;
		ring_idx = 0;
		win_sum  = '0;
		lp_acc   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_settled_ground(470);
		test_output_backpressure();
		test_drain_pause();
		test_full_rate();
		in_valid <= 1'b0;
		while (expected_ground.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_baro_ground_level_calibrator OK");
		else
			$display("tb_baro_ground_level_calibrator NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/bglc_pkg.sv
design/bglc_ring.sv
design/bglc_div.sv
design/bglc_alt.sv
design/baro_ground_level_calibrator.sv
design/bglc_checker.sv
bench/tb_baro_ground_level_calibrator.sv
